>>> rtl/rhrm_pkg.sv
// ----------------------------------------------------------------------------
// rhrm_pkg: shared types and constants of the radius Hamming ratio matcher
// Item, candidate and result records that pass between the pipeline stages,
// register indexes, request kinds and distance codes.
// ----------------------------------------------------------------------------
package rhrm_pkg;

    localparam int POS_W   = 16;
    localparam int LEVEL_W = 4;
    localparam int WORD_W  = 64;
    localparam int WORDS   = 4;
    localparam int KEY_W   = 12;
    localparam int DIST_W  = 9;
    localparam int PC_W    = 7;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // Request kinds carried in tuser on the input stream.
    localparam logic REQ_QUERY = 1'b0;
    localparam logic REQ_CAND  = 1'b1;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_RADIUS   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_DIST = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RATIO    = 2'd2;

    localparam logic [POS_W-1:0]  RADIUS_RST   = 16'd160;
    localparam logic [DIST_W-1:0] MAX_DIST_RST = 9'd64;
    localparam logic [DIST_W-1:0] RATIO_RST    = 9'd205;

    // Distance codes: nothing counted yet, and the reported value for none.
    localparam logic [DIST_W-1:0] DIST_NONE  = 9'd511;
    localparam logic [DIST_W-1:0] DIST_EMPTY = 9'd256;

    localparam logic [LEVEL_W-1:0] LEVEL_ALL = 4'hF;

    typedef logic [WORDS-1:0][WORD_W-1:0] t_desc;

    typedef struct packed {
        logic               valid;
        logic               req;
        logic [POS_W-1:0]   pos_x;
        logic [POS_W-1:0]   pos_y;
        logic [LEVEL_W-1:0] level;
        t_desc              desc;
        logic [KEY_W-1:0]   key;
        logic               last;
    } t_item;

    typedef struct packed {
        logic                       valid;
        logic                       req;
        logic                       last;
        logic                       ok;
        logic [KEY_W-1:0]           key;
        logic [WORDS-1:0][PC_W-1:0] pc;
    } t_cand;

    typedef struct packed {
        logic              valid;
        logic [DIST_W-1:0] best;
        logic [DIST_W-1:0] second;
        logic [KEY_W-1:0]  key;
    } t_final;

    typedef struct packed {
        logic              found;
        logic [KEY_W-1:0]  index;
        logic [DIST_W-1:0] distance;
    } t_result;

    // Bit count of one 64-bit word as a balanced adder tree.
    function automatic logic [PC_W-1:0] popcount64(input logic [WORD_W-1:0] v);
        logic [1:0] s2  [32];
        logic [2:0] s4  [16];
        logic [3:0] s8  [8];
        logic [4:0] s16 [4];
        logic [5:0] s32 [2];
        for (int i = 0; i < 32; i++) begin
            s2[i] = {1'b0, v[2*i]} + {1'b0, v[2*i+1]};
        end
        for (int i = 0; i < 16; i++) begin
            s4[i] = {1'b0, s2[2*i]} + {1'b0, s2[2*i+1]};
        end
        for (int i = 0; i < 8; i++) begin
            s8[i] = {1'b0, s4[2*i]} + {1'b0, s4[2*i+1]};
        end
        for (int i = 0; i < 4; i++) begin
            s16[i] = {1'b0, s8[2*i]} + {1'b0, s8[2*i+1]};
        end
        for (int i = 0; i < 2; i++) begin
            s32[i] = {1'b0, s16[2*i]} + {1'b0, s16[2*i+1]};
        end
        return {1'b0, s32[0]} + {1'b0, s32[1]};
    endfunction

endpackage

>>> rtl/radius_hamming_ratio_matcher.sv
// ----------------------------------------------------------------------------
// radius_hamming_ratio_matcher: nearest-neighbor descriptor matcher
// Radius-box keypoint search with Hamming distance and a ratio test.
// ----------------------------------------------------------------------------
// Usage:
// The input stream carries one item per transaction. tuser selects a query
// (0) or a candidate keypoint (1); tlast closes the search. A query stores
// position, level and descriptor and opens a fresh search. Candidates inside
// the radius box and level window are scored by Hamming distance against the
// query, and the best and second-best distances are tracked.
// Each transaction with tlast set yields exactly one result transaction on
// the output stream: tuser is the found flag, tdata the best keypoint index
// (zero if not found) and the best distance. After a report the query is
// kept, so more candidates start a new search against it.
// Throughput is one input transaction per cycle while the queue has room.
// A result is offered once the transaction that closed the search has
// passed the input register, loaded at that handshake, then the registered
// descriptor compare, best/second update and decision into the output queue.
// The queue holds two results; input is taken while one waits, and stops
// only when both slots are full because the receiver stalls.
// Reset clears the pipeline and the queue, restores the register defaults
// (radius 160, max distance 64, ratio 205) and empties the query, whose
// level then searches all levels. The configuration port is always ready.
// ----------------------------------------------------------------------------
module radius_hamming_ratio_matcher #(
    parameter int INDEX_BITS = 12,
    parameter int MAX_LEVEL  = 7,
    parameter int DESC_BITS  = 256
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // Input stream.
    input  logic                            i_s_axis_tvalid,
    output logic                            o_s_axis_tready,
    // tdata from bit 0: pos_x[15:0], pos_y[31:16], level[35:32],
    // desc_word0[99:36], desc_word1[163:100], desc_word2[227:164],
    // desc_word3[291:228], key_index[303:292].
    input  logic [303:0]                    i_s_axis_tdata,
    input  logic                            i_s_axis_tuser, // req_type
    input  logic                            i_s_axis_tlast, // last
    // Result stream.
    output logic                            o_m_axis_tvalid,
    input  logic                            i_m_axis_tready,
    // tdata from bit 0: match_index[11:0], best_distance[20:12], zeros above.
    output logic [23:0]                     o_m_axis_tdata,
    output logic                            o_m_axis_tuser, // found
    // Configuration write channel.
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [rhrm_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [rhrm_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import rhrm_pkg::*;

    logic [POS_W-1:0]  r_radius;
    logic [DIST_W-1:0] r_max_dist;
    logic [DIST_W-1:0] r_ratio;

    t_item   item;
    t_cand   cand;
    t_final  fin;
    t_result result;
    logic    adv;

    // Users write configuration only while the matcher is idle; not enforced.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radius   <= RADIUS_RST;
            r_max_dist <= MAX_DIST_RST;
            r_ratio    <= RATIO_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_RADIUS:   r_radius   <= i_cfg_data;
                CFG_MAX_DIST: r_max_dist <= i_cfg_data[DIST_W-1:0];
                CFG_RATIO:    r_ratio    <= i_cfg_data[DIST_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // The whole pipeline advances together; it stalls only on a full queue.
    assign o_s_axis_tready = adv;

    always_comb begin
        item.valid   = i_s_axis_tvalid;
        item.req     = i_s_axis_tuser;
        item.pos_x   = i_s_axis_tdata[15:0];
        item.pos_y   = i_s_axis_tdata[31:16];
        item.level   = i_s_axis_tdata[35:32];
        item.desc[0] = i_s_axis_tdata[99:36];
        item.desc[1] = i_s_axis_tdata[163:100];
        item.desc[2] = i_s_axis_tdata[227:164];
        item.desc[3] = i_s_axis_tdata[291:228];
        item.key     = i_s_axis_tdata[303:292];
        item.last    = i_s_axis_tlast;
    end

    rhrm_front #(
        .MAX_LEVEL (MAX_LEVEL),
        .DESC_BITS (DESC_BITS)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_adv    (adv),
        .i_item   (item),
        .i_radius (r_radius),
        .o_cand   (cand)
    );

    rhrm_track #(
        .INDEX_BITS (INDEX_BITS)
    ) u_track (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (adv),
        .i_cand  (cand),
        .o_final (fin)
    );

    rhrm_report u_report (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_final    (fin),
        .i_max_dist (r_max_dist),
        .i_ratio    (r_ratio),
        .i_ready    (i_m_axis_tready),
        .o_valid    (o_m_axis_tvalid),
        .o_result   (result),
        .o_adv      (adv)
    );

    assign o_m_axis_tdata = {3'd0, result.distance, result.index};
    assign o_m_axis_tuser = result.found;

endmodule

>>> rtl/rhrm_front.sv
// ----------------------------------------------------------------------------
// rhrm_front: input register, query store and candidate screening
// Holds the accepted item, keeps the current query, checks the search box
// and the level window, and counts differing descriptor bits per word.
// ----------------------------------------------------------------------------
module rhrm_front #(
    parameter int MAX_LEVEL = 7,
    parameter int DESC_BITS = 256
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_adv,
    input  rhrm_pkg::t_item            i_item,
    input  logic [rhrm_pkg::POS_W-1:0] i_radius,
    output rhrm_pkg::t_cand            o_cand
);
    import rhrm_pkg::*;

    localparam logic [WORDS*WORD_W-1:0] DESC_MASK =
        {(WORDS*WORD_W){1'b1}} >> (WORDS*WORD_W - DESC_BITS);
    localparam logic signed [5:0] MAXL = 6'(MAX_LEVEL);

    t_item              r_item;
    t_cand              r_cand;
    t_cand              n_cand;
    logic [POS_W-1:0]   r_qx;
    logic [POS_W-1:0]   r_qy;
    logic [LEVEL_W-1:0] r_qlevel;
    t_desc              r_qdesc;

    logic [POS_W-1:0]   dx;
    logic [POS_W-1:0]   dy;
    logic signed [5:0]  cl;
    logic signed [5:0]  ql;
    logic               box_ok;
    logic               lvl_ok;
    logic               is_query;

    assign is_query = r_item.valid && (r_item.req == REQ_QUERY);

    assign dx = (r_item.pos_x >= r_qx) ? r_item.pos_x - r_qx : r_qx - r_item.pos_x;
    assign dy = (r_item.pos_y >= r_qy) ? r_item.pos_y - r_qy : r_qy - r_item.pos_y;
    assign box_ok = (dx <= i_radius) && (dy <= i_radius);

    assign cl = signed'({{2{r_item.level[LEVEL_W-1]}}, r_item.level});
    assign ql = signed'({{2{r_qlevel[LEVEL_W-1]}}, r_qlevel});
    // A negative query level opens all levels; otherwise a window of +/-1 level.
    assign lvl_ok = (cl >= 6'sd0) && (cl <= MAXL) &&
                    ((ql < 6'sd0) || ((cl >= ql - 6'sd1) && (cl <= ql + 6'sd1)));

    always_comb begin
        n_cand.valid = r_item.valid;
        n_cand.req   = r_item.req;
        n_cand.last  = r_item.last;
        n_cand.ok    = box_ok && lvl_ok;
        n_cand.key   = r_item.key;
        for (int w = 0; w < WORDS; w++) begin
            n_cand.pc[w] = popcount64((r_item.desc[w] ^ r_qdesc[w]) &
                                      DESC_MASK[w*WORD_W +: WORD_W]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_item.valid <= 1'b0;
            r_cand.valid <= 1'b0;
            r_qx         <= '0;
            r_qy         <= '0;
            r_qlevel     <= LEVEL_ALL;
            r_qdesc      <= '0;
        end else if (i_adv) begin
            r_item <= i_item;
            r_cand <= n_cand;
            if (is_query) begin
                r_qx     <= r_item.pos_x;
                r_qy     <= r_item.pos_y;
                r_qlevel <= r_item.level;
                r_qdesc  <= r_item.desc;
            end
        end
    end

    assign o_cand = r_cand;

endmodule

>>> rtl/rhrm_track.sv
// ----------------------------------------------------------------------------
// rhrm_track: best and second-best distance tracking
// Sums the per-word counts, updates the two smallest distances and the key
// of the best one, and hands the final values over on the last item.
// ----------------------------------------------------------------------------
module rhrm_track #(
    parameter int INDEX_BITS = 12
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_adv,
    input  rhrm_pkg::t_cand  i_cand,
    output rhrm_pkg::t_final o_final
);
    import rhrm_pkg::*;

    logic [DIST_W-1:0]     r_best;
    logic [DIST_W-1:0]     r_second;
    logic [INDEX_BITS-1:0] r_key;
    t_final                r_final;

    logic [DIST_W-1:0]     base_best;
    logic [DIST_W-1:0]     base_second;
    logic [INDEX_BITS-1:0] base_key;
    logic [DIST_W-1:0]     n_best;
    logic [DIST_W-1:0]     n_second;
    logic [INDEX_BITS-1:0] n_key;
    logic [DIST_W-1:0]     cand_dist;
    logic [KEY_W+INDEX_BITS-1:0] key_in_ext;
    logic [KEY_W+INDEX_BITS-1:0] key_out_ext;

    assign cand_dist = DIST_W'(i_cand.pc[0]) + DIST_W'(i_cand.pc[1]) +
                       DIST_W'(i_cand.pc[2]) + DIST_W'(i_cand.pc[3]);
    assign key_in_ext = {{INDEX_BITS{1'b0}}, i_cand.key};

    always_comb begin
        // A query opens a fresh search before its own last flag is seen.
        if (i_cand.req == REQ_QUERY) begin
            base_best   = DIST_NONE;
            base_second = DIST_NONE;
            base_key    = '0;
        end else begin
            base_best   = r_best;
            base_second = r_second;
            base_key    = r_key;
        end
        n_best   = base_best;
        n_second = base_second;
        n_key    = base_key;
        if (i_cand.req == REQ_CAND && i_cand.ok) begin
            if (cand_dist < base_best) begin
                n_second = base_best;
                n_best   = cand_dist;
                n_key    = key_in_ext[INDEX_BITS-1:0];
            end else if (cand_dist < base_second) begin
                n_second = cand_dist;
            end
        end
    end

    assign key_out_ext = {{KEY_W{1'b0}}, n_key};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_best        <= DIST_NONE;
            r_second      <= DIST_NONE;
            r_key         <= '0;
            r_final.valid <= 1'b0;
        end else if (i_adv) begin
            r_final.valid  <= i_cand.valid && i_cand.last;
            r_final.best   <= n_best;
            r_final.second <= n_second;
            r_final.key    <= key_out_ext[KEY_W-1:0];
            if (i_cand.valid) begin
                if (i_cand.last) begin
                    r_best   <= DIST_NONE;
                    r_second <= DIST_NONE;
                    r_key    <= '0;
                end else begin
                    r_best   <= n_best;
                    r_second <= n_second;
                    r_key    <= n_key;
                end
            end
        end
    end

    assign o_final = r_final;

endmodule

>>> rtl/rhrm_report.sv
// ----------------------------------------------------------------------------
// rhrm_report: match decision and two-entry output queue
// Applies the distance limit and the ratio test, and buffers up to two
// results so the pipeline keeps moving while the receiver stalls.
// ----------------------------------------------------------------------------
module rhrm_report (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  rhrm_pkg::t_final            i_final,
    input  logic [rhrm_pkg::DIST_W-1:0] i_max_dist,
    input  logic [rhrm_pkg::DIST_W-1:0] i_ratio,
    input  logic                        i_ready,
    output logic                        o_valid,
    output rhrm_pkg::t_result           o_result,
    output logic                        o_adv
);
    import rhrm_pkg::*;

    t_result           r_head;
    t_result           r_skid;
    logic [1:0]        r_cnt;
    logic [1:0]        n_cnt;
    t_result           res;
    logic              have;
    logic              ratio_fail;
    logic [2*DIST_W-1:0] lhs;
    logic [2*DIST_W-1:0] rhs;
    logic              push;
    logic              pop;

    assign lhs = {1'b0, i_final.best, 8'd0};
    assign rhs = i_final.second * i_ratio;
    assign have = (i_final.best != DIST_NONE);
    assign ratio_fail = (i_final.second != DIST_NONE) && (lhs > rhs);

    always_comb begin
        res.found    = have && (i_final.best <= i_max_dist) && !ratio_fail;
        res.index    = res.found ? i_final.key : '0;
        res.distance = have ? i_final.best : DIST_EMPTY;
    end

    assign o_adv   = (r_cnt != 2'd2);
    assign push    = o_adv && i_final.valid;
    assign pop     = (r_cnt != 2'd0) && i_ready;
    assign n_cnt   = r_cnt + 2'(push) - 2'(pop);
    assign o_valid = (r_cnt != 2'd0);
    assign o_result = r_head;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else begin
            r_cnt <= n_cnt;
            if (push && (r_cnt == 2'd0 || (r_cnt == 2'd1 && pop))) begin
                r_head <= res;
            end else if (push) begin
                r_skid <= res;
            end else if (pop && r_cnt == 2'd2) begin
                r_head <= r_skid;
            end
        end
    end

endmodule
